@@ sv/sdes_pkg.sv @@
// Shared types, constants and helpers for the spring-damper Euler step block.
// Used by the register bank, controller, datapath, arithmetic units and top level.
// Depends on nothing.
package sdes_pkg;

	// word format: signed Q16.16
	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam int CFG_BITS  = 31;

	// magnitude of a word difference, multiplier product, truncated product
	localparam int MAG_W  = WORD_BITS + 1;
	localparam int PROD_W = MAG_W + WORD_BITS;
	localparam int MQ_W   = PROD_W - FRAC_BITS + 1;
	localparam int ACC_W  = MQ_W + 2;
	localparam int SUM_W  = 2 * WORD_BITS;

	// divider: numerator, divisor and quotient widths
	localparam int DIV_NW = MQ_W + FRAC_BITS;
	localparam int DIV_DW = MAG_W;
	localparam int DIV_QB = WORD_BITS;

	// configuration port
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic [CFG_BITS-1:0] cfg_word_t;

	// item kinds
	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_STEP  = 2'd1;
	localparam logic [1:0] KIND_TRACK = 2'd2;

	// register indexes
	localparam logic [2:0] REG_STIFF  = 3'd0;
	localparam logic [2:0] REG_DAMP   = 3'd1;
	localparam logic [2:0] REG_LENGTH = 3'd2;
	localparam logic [2:0] REG_DT     = 3'd3;
	localparam logic [2:0] REG_MASS   = 3'd4;
	localparam logic [2:0] REG_ENABLE = 3'd5;

	typedef struct packed {
		cfg_word_t k;
		cfg_word_t c;
		cfg_word_t len;
		cfg_word_t dt;
		cfg_word_t mass;
		logic      en;
	} sdes_cfg_t;

	typedef enum logic [4:0] {
		OP_IDLE, OP_LOAD, OP_TRK_DIV, OP_TRK_WB, OP_TRK_POS,
		OP_SQ_MUL, OP_SQ_ACC, OP_SQRT, OP_RL_MUL, OP_RL_DIV, OP_RL_WB,
		OP_K_MUL, OP_K_WB, OP_C_MUL, OP_C_WB, OP_A_DIV, OP_A_WB,
		OP_V_MUL, OP_V_WB, OP_P_MUL, OP_P_WB, OP_PUBLISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] axis;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic sqrt_done;
	} dp_status_t;

	// clamp a wide signed value to the word range
	function automatic word_t sat_word(input logic signed [ACC_W-1:0] x);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = {{(ACC_W-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
		lo = ~hi;
		if (x > hi) begin
			return hi[WORD_BITS-1:0];
		end else if (x < lo) begin
			return lo[WORD_BITS-1:0];
		end
		return x[WORD_BITS-1:0];
	endfunction

endpackage

@@ sv/sdes_regs.sv @@
// APB-style configuration register bank for the spring-damper block.
// Depends on sdes_pkg.
module sdes_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [sdes_pkg::ADDR_W-1:0] paddr,
	input  logic [sdes_pkg::DATA_W-1:0] pwdata,
	output logic [sdes_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output sdes_pkg::sdes_cfg_t        cfg
);
	import sdes_pkg::*;

	sdes_cfg_t  cfg_q;
	logic [2:0] idx;
	logic       wr;

	assign idx    = paddr[ADDR_W-1:2];
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// write decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.k    <= CFG_BITS'(65536);
			cfg_q.c    <= '0;
			cfg_q.len  <= '0;
			cfg_q.dt   <= CFG_BITS'(655);
			cfg_q.mass <= CFG_BITS'(65536);
			cfg_q.en   <= 1'b1;
		end else if (wr) begin
			unique case (idx)
				REG_STIFF:  cfg_q.k    <= pwdata[CFG_BITS-1:0];
				REG_DAMP:   cfg_q.c    <= pwdata[CFG_BITS-1:0];
				REG_LENGTH: cfg_q.len  <= pwdata[CFG_BITS-1:0];
				REG_DT:     cfg_q.dt   <= pwdata[CFG_BITS-1:0];
				REG_MASS:   cfg_q.mass <= pwdata[CFG_BITS-1:0];
				REG_ENABLE: cfg_q.en   <= pwdata[0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			REG_STIFF:  prdata = DATA_W'(cfg_q.k);
			REG_DAMP:   prdata = DATA_W'(cfg_q.c);
			REG_LENGTH: prdata = DATA_W'(cfg_q.len);
			REG_DT:     prdata = DATA_W'(cfg_q.dt);
			REG_MASS:   prdata = DATA_W'(cfg_q.mass);
			REG_ENABLE: prdata = DATA_W'(cfg_q.en);
			default:    prdata = '0;
		endcase
	end

endmodule

@@ sv/sdes_div.sv @@
// Restoring divider, one quotient bit per cycle, with overflow flag.
// Depends on sdes_pkg.
module sdes_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [sdes_pkg::DIV_NW-1:0] num,
	input  logic [sdes_pkg::DIV_DW-1:0] den,
	output logic [sdes_pkg::DIV_QB-1:0] quo,
	output logic                        ovf,
	output logic                        done
);
	import sdes_pkg::*;

	localparam int CW = $clog2(DIV_QB);

	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_QB-1:0] qr_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic              ovf_q;
	logic [DIV_NW-DIV_QB-1:0] top;
	logic [DIV_DW:0]   tmp;
	logic              ge;

	assign top  = num[DIV_NW-1:DIV_QB];
	assign tmp  = {rem_q, qr_q[DIV_QB-1]};
	assign ge   = tmp >= {1'b0, den_q};
	assign quo  = qr_q;
	assign ovf  = ovf_q;
	assign done = done_q;

	// shift in one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(DIV_QB - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= top[DIV_DW-1:0];
			qr_q  <= num[DIV_QB-1:0];
			den_q <= den;
			ovf_q <= top >= (DIV_NW-DIV_QB)'(den);
		end else if (busy_q) begin
			rem_q <= ge ? DIV_DW'(tmp - {1'b0, den_q}) : tmp[DIV_DW-1:0];
			qr_q  <= {qr_q[DIV_QB-2:0], ge};
		end
	end

endmodule

@@ sv/sdes_sqrt.sv @@
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on sdes_pkg.
module sdes_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [sdes_pkg::SUM_W-1:0]    radicand,
	output logic [sdes_pkg::WORD_BITS-1:0] root,
	output logic                          done
);
	import sdes_pkg::*;

	localparam int RW = WORD_BITS + 4;
	localparam int CW = $clog2(WORD_BITS);

	logic [SUM_W-1:0]     src_q;
	logic [RW-1:0]        rem_q;
	logic [WORD_BITS-1:0] root_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [RW-1:0]        rem_sh;
	logic [RW-1:0]        trial;
	logic                 ge;

	assign rem_sh = {rem_q[RW-3:0], src_q[SUM_W-1:SUM_W-2]};
	assign trial  = RW'({root_q, 2'b01});
	assign ge     = rem_sh >= trial;
	assign root   = root_q;
	assign done   = done_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(WORD_BITS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// take two radicand bits, decide one root bit
	always_ff @(posedge clk) begin
		if (start) begin
			src_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			src_q  <= {src_q[SUM_W-3:0], 2'b00};
			rem_q  <= ge ? rem_sh - trial : rem_sh;
			root_q <= {root_q[WORD_BITS-2:0], ge};
		end
	end

endmodule

@@ sv/sdes_datapath.sv @@
// Datapath: state registers, shared multiplier, divider and square root.
// Depends on sdes_pkg, sdes_div and sdes_sqrt.
module sdes_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  sdes_pkg::dp_cmd_t                    cmd,
	output sdes_pkg::dp_status_t                 status,
	input  sdes_pkg::sdes_cfg_t                  cfg,
	input  logic                                 in_fire,
	input  logic [2:0][sdes_pkg::WORD_BITS-1:0]  in_pos,
	input  logic [2:0][sdes_pkg::WORD_BITS-1:0]  in_avel,
	output logic [2:0][sdes_pkg::WORD_BITS-1:0]  out_pos,
	output logic [2:0][sdes_pkg::WORD_BITS-1:0]  out_vel
);
	import sdes_pkg::*;

	word_t p_q [3];
	word_t v_q [3];
	word_t anc_q [3];
	word_t avel_q [3];
	logic [2:0][WORD_BITS-1:0] opos_q;
	logic [2:0][WORD_BITS-1:0] ovel_q;

	logic [SUM_W-1:0]         sum_q;
	logic [PROD_W-1:0]        prod_q;
	logic                     neg_q;
	logic                     div_neg_q;
	word_t                    r_q;
	logic signed [MQ_W-1:0]   t1_q;
	logic signed [MQ_W:0]     f_q;
	word_t                    a_q;

	logic signed [MAG_W-1:0]  d_cur;
	word_t                    ds;
	logic [WORD_BITS-1:0]     mag_ds;
	logic [MAG_W-1:0]         mag_d;
	logic signed [MAG_W:0]    e;
	logic [MAG_W-1:0]         mag_e;
	logic signed [MAG_W-1:0]  dv;
	logic [MAG_W-1:0]         mag_dv;
	logic [WORD_BITS-1:0]     mag_a;
	logic [WORD_BITS-1:0]     mag_v;
	logic [MQ_W:0]            mag_f;

	logic [MAG_W-1:0]         mul_a;
	logic [WORD_BITS-1:0]     mul_b;
	logic                     mul_neg;
	logic                     mul_en;
	logic signed [MQ_W-1:0]   mulq_s;

	logic                     div_start;
	logic [DIV_NW-1:0]        div_num;
	logic [DIV_DW-1:0]        div_den;
	logic                     div_neg;
	logic [DIV_QB-1:0]        quo;
	logic                     ovf;
	logic                     div_done;
	logic [DIV_QB:0]          res_mag;
	logic signed [DIV_QB+1:0] div_sv34;
	word_t                    div_sv;

	logic                     sqrt_start;
	logic [WORD_BITS-1:0]     root_len;
	logic                     sqrt_done;

	logic [1:0]               ax;

	assign ax = cmd.axis;

	// per-axis differences and magnitudes
	always_comb begin
		d_cur  = MAG_W'(anc_q[ax]) - MAG_W'(p_q[ax]);
		ds     = sat_word(ACC_W'(d_cur));
		mag_ds = ds[WORD_BITS-1] ? WORD_BITS'(-ds) : WORD_BITS'(ds);
		mag_d  = d_cur[MAG_W-1] ? MAG_W'(-d_cur) : MAG_W'(d_cur);
		e      = (MAG_W+1)'(d_cur) - (MAG_W+1)'(r_q);
		mag_e  = e[MAG_W] ? MAG_W'(-e) : MAG_W'(e);
		dv     = MAG_W'(avel_q[ax]) - MAG_W'(v_q[ax]);
		mag_dv = dv[MAG_W-1] ? MAG_W'(-dv) : MAG_W'(dv);
		mag_a  = a_q[WORD_BITS-1] ? WORD_BITS'(-a_q) : WORD_BITS'(a_q);
		mag_v  = v_q[ax][WORD_BITS-1] ? WORD_BITS'(-v_q[ax]) : WORD_BITS'(v_q[ax]);
		mag_f  = f_q[MQ_W] ? (MQ_W+1)'(-f_q) : (MQ_W+1)'(f_q);
	end

	// multiplier operand select
	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		mul_neg = 1'b0;
		mul_en  = 1'b1;
		unique case (cmd.op)
			OP_SQ_MUL: begin
				mul_a = MAG_W'(mag_ds);
				mul_b = mag_ds;
			end
			OP_RL_MUL: begin
				mul_a = MAG_W'(mag_ds);
				mul_b = WORD_BITS'(cfg.len);
			end
			OP_K_MUL: begin
				mul_a   = mag_e;
				mul_b   = WORD_BITS'(cfg.k);
				mul_neg = e[MAG_W];
			end
			OP_C_MUL: begin
				mul_a   = mag_dv;
				mul_b   = WORD_BITS'(cfg.c);
				mul_neg = dv[MAG_W-1];
			end
			OP_V_MUL: begin
				mul_a   = MAG_W'(mag_a);
				mul_b   = WORD_BITS'(cfg.dt);
				mul_neg = a_q[WORD_BITS-1];
			end
			OP_P_MUL: begin
				mul_a   = MAG_W'(mag_v);
				mul_b   = WORD_BITS'(cfg.dt);
				mul_neg = v_q[ax][WORD_BITS-1];
			end
			default: mul_en = 1'b0;
		endcase
	end

	// truncated product, signed
	assign mulq_s = neg_q ? -$signed({1'b0, prod_q[PROD_W-1:FRAC_BITS]})
	                      : $signed({1'b0, prod_q[PROD_W-1:FRAC_BITS]});

	// divider operand select
	always_comb begin
		div_num   = '0;
		div_den   = '0;
		div_neg   = 1'b0;
		div_start = 1'b1;
		unique case (cmd.op)
			OP_TRK_DIV: begin
				div_num = {(MQ_W)'(mag_d), {FRAC_BITS{1'b0}}};
				div_den = DIV_DW'(cfg.dt);
				div_neg = d_cur[MAG_W-1];
			end
			OP_RL_DIV: begin
				div_num = DIV_NW'(prod_q);
				div_den = DIV_DW'(root_len);
			end
			OP_A_DIV: begin
				div_num = {mag_f[MQ_W-1:0], {FRAC_BITS{1'b0}}};
				div_den = DIV_DW'(cfg.mass);
				div_neg = f_q[MQ_W];
			end
			default: div_start = 1'b0;
		endcase
	end

	// clamp quotient at the word's negative limit, then sign and saturate
	always_comb begin
		if (ovf || quo[DIV_QB-1] && (quo[DIV_QB-2:0] != '0)) begin
			res_mag = (DIV_QB+1)'(1) << (WORD_BITS - 1);
		end else begin
			res_mag = (DIV_QB+1)'(quo);
		end
		div_sv34 = div_neg_q ? -$signed({1'b0, res_mag}) : $signed({1'b0, res_mag});
		div_sv   = sat_word(ACC_W'(div_sv34));
	end

	assign sqrt_start = cmd.op == OP_SQRT;

	sdes_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quo    (quo),
		.ovf    (ovf),
		.done   (div_done)
	);

	sdes_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (sum_q),
		.root     (root_len),
		.done     (sqrt_done)
	);

	assign status.div_done  = div_done;
	assign status.sqrt_done = sqrt_done;

	// state and working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				p_q[i] <= '0;
				v_q[i] <= '0;
			end
		end else begin
			unique case (cmd.op)
				OP_LOAD: begin
					for (int i = 0; i < 3; i++) begin
						p_q[i] <= anc_q[i];
						v_q[i] <= '0;
					end
				end
				OP_TRK_WB: v_q[ax] <= (cfg.dt == '0) ? word_t'(0) : div_sv;
				OP_TRK_POS: begin
					for (int i = 0; i < 3; i++) begin
						p_q[i] <= anc_q[i];
					end
				end
				OP_V_WB: v_q[ax] <= sat_word(ACC_W'(v_q[ax]) + ACC_W'(mulq_s));
				OP_P_WB: p_q[ax] <= sat_word(ACC_W'(p_q[ax]) + ACC_W'(mulq_s));
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			for (int i = 0; i < 3; i++) begin
				anc_q[i]  <= in_pos[i];
				avel_q[i] <= in_avel[i];
			end
		end
		if (mul_en) begin
			prod_q <= mul_a * mul_b;
			neg_q  <= mul_neg;
		end
		if (div_start) begin
			div_neg_q <= div_neg;
		end
		unique case (cmd.op)
			OP_SQ_ACC: sum_q <= (ax == 2'd0) ? prod_q[SUM_W-1:0] : sum_q + prod_q[SUM_W-1:0];
			OP_RL_WB: begin
				if (root_len == '0) begin
					r_q <= '0;
				end else if (d_cur[MAG_W-1]) begin
					r_q <= -$signed({1'b0, quo[WORD_BITS-2:0]});
				end else begin
					r_q <= $signed({1'b0, quo[WORD_BITS-2:0]});
				end
			end
			OP_K_WB: t1_q <= mulq_s;
			OP_C_WB: f_q <= (MQ_W+1)'(t1_q) + (MQ_W+1)'(mulq_s);
			OP_A_WB: a_q <= (cfg.mass == '0) ? word_t'(0) : div_sv;
			OP_PUBLISH: begin
				for (int i = 0; i < 3; i++) begin
					opos_q[i] <= p_q[i];
					ovel_q[i] <= v_q[i];
				end
			end
			default: ;
		endcase
	end

	assign out_pos = opos_q;
	assign out_vel = ovel_q;

endmodule

@@ sv/sdes_ctrl.sv @@
// Controller: sequences load, track and step items through the datapath.
// Depends on sdes_pkg.
module sdes_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_fire,
	input  logic [1:0]           kind,
	input  logic                 sim_enable,
	input  logic                 out_ready,
	input  sdes_pkg::dp_status_t status,
	output sdes_pkg::dp_cmd_t    cmd,
	output logic                 in_ready,
	output logic                 out_valid
);
	import sdes_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_LOAD, S_TRK_DIV, S_TRK_WAIT, S_TRK_WB, S_TRK_POS,
		S_SQ_MUL, S_SQ_ACC, S_SQRT, S_SQRT_WAIT,
		S_RL_MUL, S_RL_DIV, S_RL_WAIT, S_RL_WB,
		S_K_MUL, S_K_WB, S_C_MUL, S_C_WB,
		S_A_DIV, S_A_WAIT, S_A_WB, S_V_MUL, S_V_WB,
		S_P_MUL, S_P_WB, S_FINISH
	} state_t;

	state_t     state_q;
	logic [1:0] axis_q;
	logic       in_ready_q;
	logic       out_valid_q;
	logic       last_ax;
	logic       publish;

	assign last_ax   = axis_q == 2'd2;
	assign publish   = (state_q == S_FINISH) && (!out_valid_q || out_ready);
	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

	// command decode
	always_comb begin
		cmd.axis = axis_q;
		unique case (state_q)
			S_LOAD:    cmd.op = OP_LOAD;
			S_TRK_DIV: cmd.op = OP_TRK_DIV;
			S_TRK_WB:  cmd.op = OP_TRK_WB;
			S_TRK_POS: cmd.op = OP_TRK_POS;
			S_SQ_MUL:  cmd.op = OP_SQ_MUL;
			S_SQ_ACC:  cmd.op = OP_SQ_ACC;
			S_SQRT:    cmd.op = OP_SQRT;
			S_RL_MUL:  cmd.op = OP_RL_MUL;
			S_RL_DIV:  cmd.op = OP_RL_DIV;
			S_RL_WB:   cmd.op = OP_RL_WB;
			S_K_MUL:   cmd.op = OP_K_MUL;
			S_K_WB:    cmd.op = OP_K_WB;
			S_C_MUL:   cmd.op = OP_C_MUL;
			S_C_WB:    cmd.op = OP_C_WB;
			S_A_DIV:   cmd.op = OP_A_DIV;
			S_A_WB:    cmd.op = OP_A_WB;
			S_V_MUL:   cmd.op = OP_V_MUL;
			S_V_WB:    cmd.op = OP_V_WB;
			S_P_MUL:   cmd.op = OP_P_MUL;
			S_P_WB:    cmd.op = OP_P_WB;
			S_FINISH:  cmd.op = publish ? OP_PUBLISH : OP_IDLE;
			default:   cmd.op = OP_IDLE;
		endcase
	end

	// state, axis and handshake registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			axis_q      <= '0;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			// raise on publish, drop once the receiver takes the word
			if (publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					axis_q <= '0;
					if (in_fire) begin
						in_ready_q <= 1'b0;
						unique case (kind)
							KIND_LOAD:  state_q <= S_LOAD;
							KIND_STEP:  state_q <= sim_enable ? S_SQ_MUL : S_FINISH;
							KIND_TRACK: state_q <= S_TRK_DIV;
							default:    state_q <= S_FINISH;
						endcase
					end
				end
				S_LOAD:     state_q <= S_FINISH;
				S_TRK_DIV:  state_q <= S_TRK_WAIT;
				S_TRK_WAIT: if (status.div_done) state_q <= S_TRK_WB;
				S_TRK_WB: begin
					axis_q  <= axis_q + 1'b1;
					state_q <= last_ax ? S_TRK_POS : S_TRK_DIV;
				end
				S_TRK_POS:  state_q <= S_FINISH;
				S_SQ_MUL:   state_q <= S_SQ_ACC;
				S_SQ_ACC: begin
					axis_q  <= last_ax ? 2'd0 : axis_q + 1'b1;
					state_q <= last_ax ? S_SQRT : S_SQ_MUL;
				end
				S_SQRT:      state_q <= S_SQRT_WAIT;
				S_SQRT_WAIT: if (status.sqrt_done) state_q <= S_RL_MUL;
				S_RL_MUL:    state_q <= S_RL_DIV;
				S_RL_DIV:    state_q <= S_RL_WAIT;
				S_RL_WAIT:   if (status.div_done) state_q <= S_RL_WB;
				S_RL_WB:     state_q <= S_K_MUL;
				S_K_MUL:     state_q <= S_K_WB;
				S_K_WB:      state_q <= S_C_MUL;
				S_C_MUL:     state_q <= S_C_WB;
				S_C_WB:      state_q <= S_A_DIV;
				S_A_DIV:     state_q <= S_A_WAIT;
				S_A_WAIT:    if (status.div_done) state_q <= S_A_WB;
				S_A_WB:      state_q <= S_V_MUL;
				S_V_MUL:     state_q <= S_V_WB;
				S_V_WB: begin
					axis_q  <= last_ax ? 2'd0 : axis_q + 1'b1;
					state_q <= last_ax ? S_P_MUL : S_RL_MUL;
				end
				S_P_MUL:     state_q <= S_P_WB;
				S_P_WB: begin
					axis_q  <= axis_q + 1'b1;
					state_q <= last_ax ? S_FINISH : S_P_MUL;
				end
				S_FINISH: begin
					// hold until the output register is free
					if (publish) begin
						in_ready_q  <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ sv/spring_damper_euler_step_top.sv @@
// Top level of the spring-damper point mass block: register bank, controller, datapath.
// Depends on sdes_pkg, sdes_regs, sdes_ctrl and sdes_datapath.
//
// Usage:
//   The input channel (in_valid/in_ready) takes one word: kind plus an anchor or new
//   position and an anchor velocity. Kind 0 loads the position and clears the velocity,
//   kind 1 runs one semi-implicit Euler step against the anchored spring-damper,
//   kind 2 tracks a new position and derives the velocity from it.
//   Every word returns one output word (out_valid/out_ready) with the state after it.
//   A disabled step and the spare kind 3 return the state unchanged.
//   A step uses the shared one-bit-per-cycle divider twice per axis and the
//   square root once; a track uses three divides, one per axis.
//   One word is in work at a time; in_ready rises again when its result is written
//   to the output register. A stalled receiver holds the result there and keeps
//   the block from finishing the next word.
//   Reset clears position and velocity to zero and loads the register defaults.
//   Configuration is written over the APB-style port; keeping it to times with no word in work is up to the user.
module spring_damper_euler_step_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [sdes_pkg::ADDR_W-1:0] paddr,
	input  logic [sdes_pkg::DATA_W-1:0] pwdata,
	output logic [sdes_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 kind,
	input  logic signed [31:0]         pos_x,
	input  logic signed [31:0]         pos_y,
	input  logic signed [31:0]         pos_z,
	input  logic signed [31:0]         anchor_vel_x,
	input  logic signed [31:0]         anchor_vel_y,
	input  logic signed [31:0]         anchor_vel_z,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [31:0]         obj_pos_x,
	output logic signed [31:0]         obj_pos_y,
	output logic signed [31:0]         obj_pos_z,
	output logic signed [31:0]         obj_vel_x,
	output logic signed [31:0]         obj_vel_y,
	output logic signed [31:0]         obj_vel_z
);
	import sdes_pkg::*;

	sdes_cfg_t  cfg;
	dp_cmd_t    cmd;
	dp_status_t status;
	logic       in_fire;
	logic [2:0][WORD_BITS-1:0] in_pos;
	logic [2:0][WORD_BITS-1:0] in_avel;
	logic [2:0][WORD_BITS-1:0] out_pos;
	logic [2:0][WORD_BITS-1:0] out_vel;

	assign in_fire = in_valid & in_ready;
	assign in_pos  = {pos_z, pos_y, pos_x};
	assign in_avel = {anchor_vel_z, anchor_vel_y, anchor_vel_x};

	assign obj_pos_x = out_pos[0];
	assign obj_pos_y = out_pos[1];
	assign obj_pos_z = out_pos[2];
	assign obj_vel_x = out_vel[0];
	assign obj_vel_y = out_vel[1];
	assign obj_vel_z = out_vel[2];

	sdes_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sdes_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_fire    (in_fire),
		.kind       (kind),
		.sim_enable (cfg.en),
		.out_ready  (out_ready),
		.status     (status),
		.cmd        (cmd),
		.in_ready   (in_ready),
		.out_valid  (out_valid)
	);

	sdes_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.status  (status),
		.cfg     (cfg),
		.in_fire (in_fire),
		.in_pos  (in_pos),
		.in_avel (in_avel),
		.out_pos (out_pos),
		.out_vel (out_vel)
	);

endmodule

@@ sv/sdes_checker.sv @@
// Port-level checks for the spring-damper block, bound to the top level.
// Depends on spring_damper_euler_step_top.
module sdes_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic signed [31:0]         obj_pos_x,
	input logic signed [31:0]         obj_pos_y,
	input logic signed [31:0]         obj_pos_z,
	input logic signed [31:0]         obj_vel_x,
	input logic signed [31:0]         obj_vel_y,
	input logic signed [31:0]         obj_vel_z
);

	// a stalled word stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped while stalled");

	// a stalled word keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(obj_pos_x) && $stable(obj_pos_y) &&
			$stable(obj_pos_z) && $stable(obj_vel_x) && $stable(obj_vel_y) &&
			$stable(obj_vel_z))
		else $error("output word changed while stalled");

	// one word in work at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a word is in work");

	// a result appears only when the word in work completes
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $rose(in_ready))
		else $error("result without a completed word");

endmodule

bind spring_damper_euler_step_top sdes_checker u_sdes_checker (.*);

@@ test/tb.sv @@
// Self-checking testbench for the spring-damper Euler step block.
// Holds its own fixed-point predictor and drives the word and APB-style ports.
// Depends on sdes_pkg and spring_damper_euler_step_top.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sdes_pkg::*;

	localparam int WATCHDOG_LIMIT = 30000;
	localparam int DRAIN_CYCLES   = 400;
	localparam int MAX_REPORTS    = 10;
	localparam logic [1:0] KIND_SPARE = 2'd3;

	typedef struct {
		logic [1:0] kind;
		word_t      p[3];
		word_t      av[3];
	} mass_word_t;

	typedef struct {
		word_t pos[3];
		word_t vel[3];
	} mass_state_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] kind = KIND_LOAD;
	logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic signed [31:0] anchor_vel_x = '0, anchor_vel_y = '0, anchor_vel_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] obj_pos_x, obj_pos_y, obj_pos_z;
	logic signed [31:0] obj_vel_x, obj_vel_y, obj_vel_z;

	spring_damper_euler_step_top i_dut (.*);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow configuration and state of the mass
	longint unsigned sh_k, sh_c, sh_len, sh_dt, sh_mass;
	logic sh_en;
	longint mass_pos[3], mass_vel[3];

	mass_word_t  word_q[$];
	mass_state_t state_q[$];
	mass_word_t  drv_word;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_req_cnt = 0;
	int hold_seen_cnt = 0;
	int hold_left = 0;
	int mismatches = 0;
	int idle_cycles = 0;

	function automatic longint sat32(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	function automatic longint unsigned magn(longint a);
		return (a < 0) ? longint'(-a) : longint'(a);
	endfunction

	// a * b / 2^16, toward zero
	function automatic longint qmul(longint a, longint unsigned b);
		longint unsigned p;
		p = (magn(a) * b) >> FRAC_BITS;
		if (a < 0) return -longint'(p);
		return longint'(p);
	endfunction

	// n * 2^16 / d, toward zero, clamped
	function automatic longint qdiv(longint n, longint unsigned d);
		longint unsigned cap, m, q, r, res;
		cap = 64'd2147483648;
		m = magn(n);
		q = m / d;
		r = m % d;
		if (q > (cap >> FRAC_BITS)) begin
			res = cap;
		end else begin
			res = (q << FRAC_BITS) + (r << FRAC_BITS) / d;
			if (res > cap) res = cap;
		end
		if (n < 0) return sat32(-longint'(res));
		return sat32(longint'(res));
	endfunction

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// advance the mass one Euler step against the anchor
	function automatic void euler_advance(mass_word_t w);
		longint d[3], ds[3];
		longint unsigned sum, span, rm;
		longint r, f, a;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			d[i] = longint'(w.p[i]) - mass_pos[i];
			ds[i] = sat32(d[i]);
			sum += magn(ds[i]) * magn(ds[i]);
		end
		span = root_floor(sum);
		for (int i = 0; i < 3; i++) begin
			r = 0;
			a = 0;
			if (span != 0) begin
				rm = (sh_len * magn(ds[i])) / span;
				r = (ds[i] < 0) ? -longint'(rm) : longint'(rm);
			end
			f = qmul(d[i] - r, sh_k) + qmul(longint'(w.av[i]) - mass_vel[i], sh_c);
			if (sh_mass != 0) a = qdiv(f, sh_mass);
			mass_vel[i] = sat32(mass_vel[i] + qmul(a, sh_dt));
		end
		for (int i = 0; i < 3; i++)
			mass_pos[i] = sat32(mass_pos[i] + qmul(mass_vel[i], sh_dt));
	endfunction

	// update the shadow state for one word and queue the state it returns
	function automatic void predict_state(mass_word_t w);
		mass_state_t s;
		case (w.kind)
			KIND_LOAD: begin
				for (int i = 0; i < 3; i++) begin
					mass_pos[i] = w.p[i];
					mass_vel[i] = 0;
				end
			end
			KIND_STEP: begin
				if (sh_en) euler_advance(w);
			end
			KIND_TRACK: begin
				for (int i = 0; i < 3; i++) begin
					mass_vel[i] = (sh_dt != 0) ? qdiv(longint'(w.p[i]) - mass_pos[i], sh_dt) : 0;
					mass_pos[i] = w.p[i];
				end
			end
			default: ;
		endcase
		for (int i = 0; i < 3; i++) begin
			s.pos[i] = mass_pos[i][31:0];
			s.vel[i] = mass_vel[i][31:0];
		end
		state_q.push_back(s);
	endfunction

	// driver: offer the next word, hold it until taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) predict_state(drv_word);
			if (!in_valid || in_ready) begin
				if (word_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					drv_word = word_q.pop_front();
					in_valid <= 1'b1;
					kind <= drv_word.kind;
					pos_x <= drv_word.p[0];
					pos_y <= drv_word.p[1];
					pos_z <= drv_word.p[2];
					anchor_vel_x <= drv_word.av[0];
					anchor_vel_y <= drv_word.av[1];
					anchor_vel_z <= drv_word.av[2];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each result word with the oldest predicted state
	always @(posedge clk) begin
		mass_state_t e;
		logic signed [31:0] got[6];
		logic signed [31:0] want[6];
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = '{obj_pos_x, obj_pos_y, obj_pos_z, obj_vel_x, obj_vel_y, obj_vel_z};
				if (state_q.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected result word at %0t", $realtime);
				end else begin
					e = state_q.pop_front();
					want = '{e.pos[0], e.pos[1], e.pos[2], e.vel[0], e.vel[1], e.vel[2]};
					if (got != want) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("state mismatch at %0t: exp %p got %p", $realtime, want, got);
					end
				end
			end
			// long hold-off on request, else random stalls
			if (hold_seen_cnt != hold_req_cnt) begin
				hold_seen_cnt <= hold_req_cnt;
				hold_left <= 600;
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// watchdog on cycles without any accepted word or register access
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, longint unsigned value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= value[31:0];
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_STIFF:  sh_k = value & 64'h7FFFFFFF;
			REG_DAMP:   sh_c = value & 64'h7FFFFFFF;
			REG_LENGTH: sh_len = value & 64'h7FFFFFFF;
			REG_DT:     sh_dt = value & 64'h7FFFFFFF;
			REG_MASS:   sh_mass = value & 64'h7FFFFFFF;
			default:    sh_en = value[0];
		endcase
	endtask

	task automatic set_params(longint unsigned k, longint unsigned c, longint unsigned len,
			longint unsigned dt, longint unsigned m, logic en);
		write_reg(REG_STIFF, k);
		write_reg(REG_DAMP, c);
		write_reg(REG_LENGTH, len);
		write_reg(REG_DT, dt);
		write_reg(REG_MASS, m);
		write_reg(REG_ENABLE, en);
	endtask

	// wait until every queued word is taken and every result has come
	task automatic drain();
		while (word_q.size() != 0 || in_valid || state_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic word_t pick_coord();
		case ($urandom_range(5))
			0:       return $urandom;
			1:       return word_t'($urandom_range(32'h7FFFF)) - 32'sh40000;
			2:       return word_t'($urandom_range(32'h3FFFFFF)) - 32'sh2000000;
			3:       return word_t'($urandom_range(32'hFFFFFF)) - 32'sh800000;
			4: begin
				case ($urandom_range(3))
					0: return 32'sh7FFFFFFF;
					1: return 32'sh80000000;
					2: return 32'sh0;
					default: return -32'sh1;
				endcase
			end
			default: return word_t'($urandom_range(32'h1FFFFF)) - 32'sh100000;
		endcase
	endfunction

	function automatic mass_word_t make_word(logic [1:0] k);
		mass_word_t w;
		w.kind = k;
		for (int i = 0; i < 3; i++) begin
			w.p[i] = pick_coord();
			w.av[i] = pick_coord();
		end
		return w;
	endfunction

	function automatic mass_word_t fixed_word(logic [1:0] k, word_t p, word_t av);
		mass_word_t w;
		w.kind = k;
		w.p = '{p, p, p};
		w.av = '{av, av, av};
		return w;
	endfunction

	// mostly load / step run / track sequences, some noise
	task automatic push_random(int count);
		int n;
		n = 0;
		while (n < count) begin
			if ($urandom_range(99) < 85) begin
				word_q.push_back(make_word(KIND_LOAD));
				n++;
				repeat ($urandom_range(6, 2)) begin
					word_q.push_back(make_word(KIND_STEP));
					n++;
				end
				if ($urandom_range(1)) begin
					word_q.push_back(make_word(KIND_TRACK));
					n++;
				end
			end else begin
				word_q.push_back(make_word(2'($urandom_range(3))));
				n++;
			end
		end
	endtask

	initial begin
		sh_k = 65536;
		sh_c = 0;
		sh_len = 0;
		sh_dt = 655;
		sh_mass = 65536;
		sh_en = 1'b1;
		for (int i = 0; i < 3; i++) begin
			mass_pos[i] = 0;
			mass_vel[i] = 0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: field extremes, every kind, zero distance
		word_q.push_back(fixed_word(KIND_STEP, 32'sh0, 32'sh0));
		word_q.push_back(fixed_word(KIND_LOAD, 32'sh7FFFFFFF, 32'sh0));
		word_q.push_back(fixed_word(KIND_STEP, 32'sh80000000, 32'sh7FFFFFFF));
		word_q.push_back(fixed_word(KIND_TRACK, 32'sh80000000, 32'sh0));
		word_q.push_back(fixed_word(KIND_SPARE, 32'sh12345678, -32'sh1));
		word_q.push_back(fixed_word(KIND_LOAD, 32'sh10000, 32'sh0));
		word_q.push_back(fixed_word(KIND_STEP, 32'sh10000, 32'sh80000000));
		word_q.push_back(fixed_word(KIND_STEP, 32'sh50000, 32'sh10000));
		word_q.push_back(fixed_word(KIND_TRACK, 32'sh7FFFFFFF, 32'sh0));
		drain();
		set_params(64'h7FFFFFFF, 64'h7FFFFFFF, 64'h7FFFFFFF, 64'h7FFFFFFF, 1, 1'b1);
		word_q.push_back(fixed_word(KIND_LOAD, -32'sh30000, 32'sh0));
		word_q.push_back(fixed_word(KIND_STEP, 32'sh20000, 32'sh7FFFFFFF));
		word_q.push_back(fixed_word(KIND_TRACK, 32'sh80000000, 32'sh0));
		drain();
		// disabled steps, zero mass, zero time step
		set_params(65536, 6553, 32768, 6553, 0, 1'b0);
		word_q.push_back(fixed_word(KIND_LOAD, 32'sh10000, 32'sh0));
		word_q.push_back(fixed_word(KIND_STEP, 32'sh40000, 32'sh10000));
		drain();
		write_reg(REG_ENABLE, 1);
		word_q.push_back(fixed_word(KIND_STEP, 32'sh40000, 32'sh10000));
		drain();
		write_reg(REG_DT, 0);
		word_q.push_back(fixed_word(KIND_TRACK, 32'sh20000, 32'sh0));
		word_q.push_back(fixed_word(KIND_STEP, 32'sh20000, 32'sh0));
		drain();

		// random phases over several settings and idling patterns
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_params(65536, 0, 0, 655, 65536, 1'b1);
				1: set_params($urandom_range(32'h80000), $urandom_range(32'h20000),
						$urandom_range(32'h100000), $urandom_range(32'h4000, 1),
						$urandom_range(32'h40000, 32'h1000), 1'b1);
				2: set_params(64'h7FFFFFFF, 64'h7FFFFFFF, 64'h7FFFFFFF, 64'h7FFFFFFF,
						64'h7FFFFFFF, 1'b1);
				3: set_params(0, 0, 0, 1, 1, 1'b1);
				4: set_params($urandom, $urandom, $urandom, $urandom_range(32'h10000, 1),
						$urandom_range(32'h7FFFFFFF, 1), 1'b1);
				default: set_params(32768, 3277, 65536, 1311, 65536, 1'b1);
			endcase
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
				default: begin send_idle_pct = 20; recv_stall_pct = 20; end
			endcase
			push_random(105);
			// hold the receiver off while words keep coming
			if (ph == 2) begin
				repeat (20) @(posedge clk);
				hold_req_cnt++;
			end
			drain();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && state_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
